// ===== rtl/core/scl_pkg.sv =====
// shared types, constants and lookup tables for the stereo compressor limiter
`default_nettype none
package scl_pkg;

  localparam int unsigned SampleW = 24;
  localparam int unsigned LevelW  = 23;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned CountW  = 32;
  localparam int unsigned GainW   = 17;
  localparam int unsigned QuoW    = 16;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDatW = 32;

  localparam logic [GainW-1:0]   GainOne    = 17'd65536;
  localparam logic [LevelW-1:0]  ClampLevel = 23'd8380219;
  localparam logic [LevelW-1:0]  ThrReset   = 23'd8388607;
  localparam logic [SampleW-1:0] TinyLevel  = 24'd1;
  localparam logic [CountW-1:0]  CountMax   = '1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_COMP_EN   = 4'd0,
    REG_LIM_EN    = 4'd1,
    REG_THRESHOLD = 4'd2,
    REG_SLOPE     = 4'd3,
    REG_ATTACK    = 4'd4,
    REG_RELEASE   = 4'd5,
    REG_CEILING   = 4'd6,
    REG_LIM_REL   = 4'd7
  } cfg_reg_e;

  // log2(1+i/16) in Q1.16
  function automatic logic [16:0] log_tab(input logic [4:0] i);
    logic [16:0] v;
    unique case (i)
      5'd0:  v = 17'd0;
      5'd1:  v = 17'd5732;
      5'd2:  v = 17'd11136;
      5'd3:  v = 17'd16248;
      5'd4:  v = 17'd21098;
      5'd5:  v = 17'd25711;
      5'd6:  v = 17'd30109;
      5'd7:  v = 17'd34312;
      5'd8:  v = 17'd38336;
      5'd9:  v = 17'd42196;
      5'd10: v = 17'd45904;
      5'd11: v = 17'd49472;
      5'd12: v = 17'd52911;
      5'd13: v = 17'd56229;
      5'd14: v = 17'd59434;
      5'd15: v = 17'd62534;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

  // 2^(-i/16) in Q1.16
  function automatic logic [16:0] exp_tab(input logic [4:0] i);
    logic [16:0] v;
    unique case (i)
      5'd0:  v = 17'd65536;
      5'd1:  v = 17'd62757;
      5'd2:  v = 17'd60097;
      5'd3:  v = 17'd57549;
      5'd4:  v = 17'd55109;
      5'd5:  v = 17'd52772;
      5'd6:  v = 17'd50535;
      5'd7:  v = 17'd48393;
      5'd8:  v = 17'd46341;
      5'd9:  v = 17'd44376;
      5'd10: v = 17'd42495;
      5'd11: v = 17'd40693;
      5'd12: v = 17'd38968;
      5'd13: v = 17'd37316;
      5'd14: v = 17'd35734;
      5'd15: v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/scl_div.sv =====
// restoring divider, one quotient bit per cycle, for the limiter target
`default_nettype none
module scl_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [scl_pkg::LevelW-1:0]    num_i,
  input  wire logic [scl_pkg::SampleW-1:0]   den_i,
  output logic                               done_o,
  output logic [scl_pkg::QuoW-1:0]           quo_o
);

  localparam int unsigned CntW = $clog2(scl_pkg::QuoW + 1);

  logic [scl_pkg::SampleW:0]   rem_q, rem_d;
  logic [scl_pkg::SampleW-1:0] den_q;
  logic [scl_pkg::QuoW-1:0]    quo_q, quo_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic                        busy_q, busy_d, done_q, done_d;
  logic [scl_pkg::SampleW:0]   shifted;

  // numerator is below the divisor, so the quotient fits QuoW bits
  always_comb begin
    shifted = {rem_q[scl_pkg::SampleW-1:0], 1'b0};
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      rem_d  = {2'b00, num_i};
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shifted >= {1'b0, den_q}) begin
        rem_d = shifted - {1'b0, den_q};
        quo_d = {quo_q[scl_pkg::QuoW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[scl_pkg::QuoW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(scl_pkg::QuoW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

// ===== rtl/core/stereo_compressor_limiter_top.sv =====
// stereo peak compressor and limiter, sequenced over one shared multiplier
//
//  channel  direction  handshake                  payload
//  in       sink       in_valid_i / in_ready_o    left_in_i, right_in_i, block_end_i
//  out      source     out_valid_o / out_ready_i  left_out_o .. clip_total_o
//  cfg      sink       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// a frame is shortest from accept to accept with both stages off and longest with
// compressor and limiter active and the division taken; the single 32x17
// multiplier (one product per cycle, registered) and the 16-step divider set
// the frame time
// in_ready_o is high only while the sequencer is idle; a finished frame sits
// in the output register, so the next frame can run while it waits
// rst_ni clears control and persistent state at once; no clearing pass
// configuration writes are taken only while the sequencer is idle and no
// frame is offered
`default_nettype none
module stereo_compressor_limiter_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [scl_pkg::SampleW-1:0]  left_in_i,
  input  wire logic signed [scl_pkg::SampleW-1:0]  right_in_i,
  input  wire logic                                block_end_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [scl_pkg::SampleW-1:0]       left_out_o,
  output logic signed [scl_pkg::SampleW-1:0]       right_out_o,
  output logic                                     limiter_hit_o,
  output logic [1:0]                               clipped_o,
  output logic [scl_pkg::LevelW-1:0]               block_peak_o,
  output logic [31:0]                              limiter_total_o,
  output logic [31:0]                              clip_total_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [scl_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  wire logic [scl_pkg::CfgDatW-1:0]         cfg_data_i
);

  localparam int unsigned SW = scl_pkg::SampleW;
  localparam int unsigned LW = scl_pkg::LevelW;
  localparam int unsigned CW = scl_pkg::CoefW;
  localparam int unsigned GW = scl_pkg::GainW;
  localparam int unsigned MA = 32;            // multiplier a width
  localparam int unsigned MP = MA + GW;       // product width
  localparam int unsigned DW = 21;            // log2 domain, Q5.16

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_ENV   = 17'h00002,
    S_ENVW  = 17'h00004,
    S_LOGE  = 17'h00008,
    S_LOGT  = 17'h00010,
    S_LOGW  = 17'h00020,
    S_SLOPE = 17'h00040,
    S_EXP   = 17'h00080,
    S_EXPW  = 17'h00100,
    S_SCL   = 17'h00200,
    S_SCR   = 17'h00400,
    S_SCW   = 17'h00800,
    S_LIM   = 17'h01000,
    S_DIV   = 17'h02000,
    S_LDEC  = 17'h04000,
    S_LREL  = 17'h08000,
    S_OUT   = 17'h10000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic          comp_en_q, lim_en_q;
  logic [LW-1:0] thr_q, ceil_q;
  logic [CW-1:0] slope_q, att_q, rel_q, lrel_q;

  // datapath state
  logic [SW-1:0]        env_q;
  logic [GW-1:0]        gain_q;
  logic [LW-1:0]        peak_q;
  logic [scl_pkg::CountW-1:0] lcnt_q, ccnt_q;

  // per-frame working registers
  logic signed [SW-1:0] l_q, r_q;
  logic                 bend_q;
  logic [SW-1:0]        pk_q;
  logic [DW-1:0]        base_q, le_q, diff_q;
  logic [4:0]           n_q;
  logic [3:0]           eidx_q;
  logic [GW-1:0]        g_q, target_q;
  logic                 phase_q, hit_q;

  // output register
  logic                 ov_q;
  logic signed [SW-1:0] lo_q, ro_q;
  logic                 hito_q;
  logic [1:0]           clipo_q;
  logic [LW-1:0]        bpeak_q;
  logic [31:0]          ltot_q, ctot_q;

  // shared multiplier, product registered
  logic [MA-1:0] mul_a;
  logic [GW-1:0] mul_b;
  logic [MP-1:0] prod_q;

  logic in_fire, cfg_fire, out_free;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = (state_q == S_IDLE) && !in_valid_i;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign out_free    = !ov_q || out_ready_i;

  function automatic logic [SW-1:0] mag(input logic signed [SW-1:0] s);
    return s[SW-1] ? SW'(-s) : SW'(s);
  endfunction

  // log2 front end: leading-one position and table index of one operand
  logic [SW-1:0] log_arg;
  logic [4:0]    log_e;
  logic [31:0]   log_norm;
  logic [3:0]    log_idx;
  logic [26:0]   log_rem;
  logic [DW-1:0] log_base;
  logic [GW-1:0] log_delta;

  always_comb begin
    log_arg = (state_q == S_LOGE) ? env_q : {1'b0, thr_q};
    if (log_arg < scl_pkg::TinyLevel) log_arg = scl_pkg::TinyLevel;
    log_e = '0;
    for (int i = 1; i < SW; i++) begin
      if (log_arg[i]) log_e = 5'(i);
    end
    log_norm  = {8'd0, log_arg} << (5'd31 - log_e);
    log_idx   = log_norm[30:27];
    log_rem   = log_norm[26:0];
    log_base  = {log_e, 16'd0} + DW'(scl_pkg::log_tab({1'b0, log_idx}));
    log_delta = scl_pkg::log_tab({1'b0, log_idx} + 5'd1)
              - scl_pkg::log_tab({1'b0, log_idx});
  end

  // exponent front end from the slope product
  logic [DW-1:0] d_val;
  logic [3:0]    exp_idx;
  logic [11:0]   exp_rem;
  assign d_val   = prod_q[DW+15:16];
  assign exp_idx = d_val[15:12];
  assign exp_rem = d_val[11:0];

  // rounded scaling result from the product
  logic [SW:0] scl_mag;
  assign scl_mag = (SW+1)'(({1'b0, prod_q[40:0]} + 42'd32768) >> 16);

  logic          pk_up;
  logic [SW-1:0] env_new, mag_l, mag_r, p2;
  assign pk_up   = pk_q > env_q;
  assign env_new = pk_up ? pk_q - SW'(prod_q[MP-1:16]) : pk_q + SW'(prod_q[MP-1:16]);
  assign mag_l   = mag(l_q);
  assign mag_r   = mag(r_q);
  assign p2      = (mag_l > mag_r) ? mag_l : mag_r;

  // divider for ceiling*65536/peak
  logic                     div_start, div_done;
  logic [scl_pkg::QuoW-1:0] div_quo;
  logic                     div_need;
  assign div_need  = (p2 > {1'b0, ceil_q}) && (p2 > scl_pkg::TinyLevel);
  assign div_start = (state_q == S_LIM) && lim_en_q && div_need;

  scl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (ceil_q),
    .den_i   (p2),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_ENV: begin
        mul_a = MA'(pk_up ? pk_q - env_q : env_q - pk_q);
        mul_b = GW'(pk_up ? att_q : rel_q);
      end
      S_LOGE, S_LOGT: begin
        mul_a = MA'(log_rem);
        mul_b = log_delta;
      end
      S_SLOPE: begin
        mul_a = MA'(diff_q);
        mul_b = GW'(slope_q);
      end
      S_EXP: begin
        mul_a = MA'(exp_rem);
        mul_b = scl_pkg::exp_tab({1'b0, exp_idx}) - scl_pkg::exp_tab({1'b0, exp_idx} + 5'd1);
      end
      S_SCL: begin
        mul_a = MA'(mag_l);
        mul_b = g_q;
      end
      S_SCR: begin
        mul_a = MA'(mag_r);
        mul_b = g_q;
      end
      S_LDEC: begin
        mul_a = MA'(scl_pkg::GainOne - gain_q);
        mul_b = GW'(lrel_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= MP'(mul_a) * MP'(mul_b);
  end

  // output-stage values
  logic signed [SW-1:0] l_cl, r_cl;
  logic [SW-1:0]        ml, mr;
  logic [1:0]           clips;
  logic [LW-1:0]        peak_new;
  logic [scl_pkg::CountW-1:0] ccnt_new;
  localparam logic signed [SW-1:0] ClampPos = SW'(scl_pkg::ClampLevel);
  localparam logic signed [SW-1:0] ClampNeg = -ClampPos;

  always_comb begin
    l_cl = (l_q > ClampPos) ? ClampPos : ((l_q < ClampNeg) ? ClampNeg : l_q);
    r_cl = (r_q > ClampPos) ? ClampPos : ((r_q < ClampNeg) ? ClampNeg : r_q);
    ml   = mag(l_cl);
    mr   = mag(r_cl);
    clips = 2'(ml >= SW'(scl_pkg::ClampLevel)) + 2'(mr >= SW'(scl_pkg::ClampLevel));
    peak_new = peak_q;
    if (ml > SW'(peak_new)) peak_new = LW'(ml);
    if (mr > SW'(peak_new)) peak_new = LW'(mr);
    ccnt_new = (scl_pkg::CountMax - ccnt_q < scl_pkg::CountW'(clips))
             ? scl_pkg::CountMax : ccnt_q + scl_pkg::CountW'(clips);
  end

  // sequencer
  // table index held from the slope product, the product register now
  // carries the interpolation term
  logic [GW-1:0] exp_g;
  always_comb begin
    exp_g = scl_pkg::exp_tab({1'b0, eidx_q}) - GW'(prod_q[MP-1:12]);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_ENV;
      S_ENV:   state_d = S_ENVW;
      S_ENVW:  state_d = (comp_en_q && slope_q != '0 && env_new > {1'b0, thr_q})
                         ? S_LOGE : S_LIM;
      S_LOGE:  state_d = S_LOGT;
      S_LOGT:  state_d = S_LOGW;
      S_LOGW:  state_d = S_SLOPE;
      S_SLOPE: state_d = S_EXP;
      S_EXP:   state_d = S_EXPW;
      S_EXPW:  state_d = S_SCL;
      S_SCL:   state_d = S_SCR;
      S_SCR:   state_d = S_SCW;
      S_SCW:   state_d = phase_q ? S_OUT : S_LIM;
      S_LIM:   state_d = !lim_en_q ? S_OUT : (div_need ? S_DIV : S_LDEC);
      S_DIV:   if (div_done) state_d = S_LDEC;
      S_LDEC:  state_d = (target_q < gain_q) ? S_SCL : S_LREL;
      S_LREL:  state_d = S_SCL;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control and persistent state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      comp_en_q <= 1'b0;
      lim_en_q  <= 1'b0;
      thr_q     <= scl_pkg::ThrReset;
      slope_q   <= '0;
      att_q     <= '0;
      rel_q     <= '0;
      ceil_q    <= scl_pkg::ClampLevel;
      lrel_q    <= '0;
      env_q     <= '0;
      gain_q    <= scl_pkg::GainOne;
      peak_q    <= '0;
      lcnt_q    <= '0;
      ccnt_q    <= '0;
      ov_q      <= 1'b0;
      phase_q   <= 1'b0;
      hit_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_fire) begin
        unique case (cfg_index_i)
          scl_pkg::REG_COMP_EN:   comp_en_q <= cfg_data_i[0];
          scl_pkg::REG_LIM_EN:    lim_en_q  <= cfg_data_i[0];
          scl_pkg::REG_THRESHOLD: thr_q     <= cfg_data_i[LW-1:0];
          scl_pkg::REG_SLOPE:     slope_q   <= cfg_data_i[CW-1:0];
          scl_pkg::REG_ATTACK:    att_q     <= cfg_data_i[CW-1:0];
          scl_pkg::REG_RELEASE:   rel_q     <= cfg_data_i[CW-1:0];
          scl_pkg::REG_CEILING:   ceil_q    <= cfg_data_i[LW-1:0];
          scl_pkg::REG_LIM_REL:   lrel_q    <= cfg_data_i[CW-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        phase_q <= 1'b0;
        hit_q   <= 1'b0;
      end
      if (state_q == S_ENVW) env_q <= env_new;
      if (state_q == S_LIM) phase_q <= 1'b1;
      if (state_q == S_LDEC && target_q < gain_q) begin
        gain_q <= target_q;
        hit_q  <= 1'b1;
        if (lcnt_q != scl_pkg::CountMax) lcnt_q <= lcnt_q + 1'b1;
      end
      if (state_q == S_LREL) gain_q <= scl_pkg::GainOne - GW'(prod_q[MP-1:16]);
      if (state_q == S_OUT && out_free) ov_q <= 1'b1;
      else if (out_ready_i)             ov_q <= 1'b0;
      if (state_q == S_OUT && out_free) begin
        ccnt_q <= ccnt_new;
        peak_q <= bend_q ? '0 : peak_new;
      end
    end
  end

  // frame payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      l_q    <= left_in_i;
      r_q    <= right_in_i;
      bend_q <= block_end_i;
      pk_q   <= (mag(left_in_i) > mag(right_in_i)) ? mag(left_in_i) : mag(right_in_i);
    end
    if (state_q == S_LOGE) base_q <= log_base;
    if (state_q == S_LOGT) begin
      le_q   <= base_q + DW'(prod_q[MP-1:27]);
      base_q <= log_base;
    end
    if (state_q == S_LOGW) begin
      diff_q <= (le_q > base_q + DW'(prod_q[MP-1:27]))
              ? le_q - (base_q + DW'(prod_q[MP-1:27])) : '0;
    end
    if (state_q == S_EXP) begin
      n_q    <= (d_val[DW-1:16] > 5'd16) ? 5'd31 : d_val[DW-1:16];
      eidx_q <= exp_idx;
    end
    if (state_q == S_EXPW) g_q <= (n_q > 5'd16) ? '0 : (exp_g >> n_q);
    if (state_q == S_SCR) l_q <= l_q[SW-1] ? -SW'(scl_mag) : SW'(scl_mag);
    if (state_q == S_SCW) r_q <= r_q[SW-1] ? -SW'(scl_mag) : SW'(scl_mag);
    if (state_q == S_LIM) target_q <= scl_pkg::GainOne;
    if (state_q == S_DIV && div_done) target_q <= GW'(div_quo);
    if (state_q == S_LDEC) g_q <= target_q;
    if (state_q == S_LREL) g_q <= scl_pkg::GainOne - GW'(prod_q[MP-1:16]);
    if (state_q == S_OUT && out_free) begin
      lo_q    <= l_cl;
      ro_q    <= r_cl;
      hito_q  <= hit_q;
      clipo_q <= clips;
      bpeak_q <= peak_new;
      ltot_q  <= lcnt_q[31:0];
      ctot_q  <= ccnt_new[31:0];
    end
  end

  assign out_valid_o     = ov_q;
  assign left_out_o      = lo_q;
  assign right_out_o     = ro_q;
  assign limiter_hit_o   = hito_q;
  assign clipped_o       = clipo_q;
  assign block_peak_o    = bpeak_q;
  assign limiter_total_o = ltot_q;
  assign clip_total_o    = ctot_q;

  // limiter gain never exceeds unity
  a_gain_unity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gain_q <= scl_pkg::GainOne)
    else $error("limiter gain above unity");

  // a new result only comes from the output state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OUT))
    else $error("result loaded outside output state");

  // divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("unexpected divider completion");

  // reported peak stays within the clamp
  a_peak_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> block_peak_o <= scl_pkg::ClampLevel)
    else $error("block peak beyond clamp");

endmodule
`default_nettype wire
